/* rtl/core/fqa_pkg.sv */
package fqa_pkg;

    // queue geometry
    localparam int unsigned DEPTH     = 256;
    localparam int unsigned TIME_BITS = 32;
    localparam int unsigned CNT_W     = $clog2(DEPTH + 1);

    localparam logic [CNT_W-1:0] CNT_ZERO = '0;
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    typedef logic [TIME_BITS-1:0] time_t;

    // operation codes, code 3 leaves the queue unchanged and reports ok
    typedef enum logic [1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_AGE = 2'd2
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // one queued request record
    typedef struct packed {
        time_t arrival;
        time_t service;
        time_t waited;
    } rec_t;

    // per-cell control from the queue controller
    typedef struct packed {
        logic shift;
        logic load;
        logic age;
    } cell_ctl_t;

    // saturating add of two times
    function automatic time_t sat_add(time_t a, time_t b);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum[TIME_BITS])
        begin
            return '1;
        end
        return sum[TIME_BITS-1:0];
    endfunction

endpackage

/* rtl/core/fifo_queue_with_wait_aging_unit.sv */
// a result is registered and appears in the cycle after its beat is accepted
// throughput: one operation per cycle while the result side takes every beat
// storage is a row of cells; the head record always sits in the first cell,
// a dequeue shifts every cell one place and an age updates all cells at once
// reset clears the record count, the status and the output valid; cell contents stay undefined
module fifo_queue_with_wait_aging_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [31:0] arrival,
    input  logic [31:0] service_time,
    input  logic [31:0] wait_time,
    input  logic [31:0] elapsed_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] out_arrival,
    output logic [31:0] out_service,
    output logic [31:0] out_wait,
    output logic [8:0]  occupancy,
    output logic        is_empty
);

    logic                              in_acc;
    logic                              enq_ok;
    logic                              deq_ok;
    logic                              age_op;
    fqa_pkg::status_t                  status_next;
    fqa_pkg::status_t                  status_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [fqa_pkg::CNT_W-1:0]         count_reg;
    logic [fqa_pkg::CNT_W-1:0]         count_next;
    fqa_pkg::rec_t                     out_rec_reg;
    fqa_pkg::rec_t                     out_rec_next;
    fqa_pkg::rec_t                     load_rec;
    fqa_pkg::rec_t                     cell_rec [fqa_pkg::DEPTH];

    // hold off new beats only while a result waits to be taken
    assign in_stall = out_valid_reg && out_stall;
    assign in_acc   = in_valid && !in_stall;

    assign load_rec.arrival = arrival;
    assign load_rec.service = service_time;
    assign load_rec.waited  = wait_time;

    // operation decode
    always_comb
    begin
        enq_ok      = 1'b0;
        deq_ok      = 1'b0;
        age_op      = 1'b0;
        status_next = fqa_pkg::ST_OK;
        case (req_type)
            fqa_pkg::OP_ENQ:
            begin
                if (count_reg == fqa_pkg::CNT_FULL)
                begin
                    status_next = fqa_pkg::ST_FULL;
                end
                else
                begin
                    enq_ok = in_acc;
                end
            end
            fqa_pkg::OP_DEQ:
            begin
                if (count_reg == fqa_pkg::CNT_ZERO)
                begin
                    status_next = fqa_pkg::ST_EMPTY;
                end
                else
                begin
                    deq_ok = in_acc;
                end
            end
            fqa_pkg::OP_AGE:
            begin
                age_op = in_acc;
            end
            default:
            begin
                status_next = fqa_pkg::ST_OK;
            end
        endcase
    end

    // count and output staging
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_rec_next   = out_rec_reg;
        if (enq_ok)
        begin
            count_next = count_reg + fqa_pkg::CNT_ONE;
        end
        else if (deq_ok)
        begin
            count_next = count_reg - fqa_pkg::CNT_ONE;
        end
        if (in_acc)
        begin
            out_valid_next = 1'b1;
            out_rec_next   = deq_ok ? cell_rec[0] : '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= fqa_pkg::CNT_ZERO;
            out_valid_reg <= 1'b0;
            status_reg    <= fqa_pkg::ST_OK;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (in_acc)
            begin
                status_reg <= status_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_rec_reg <= out_rec_next;
    end

    // row of record cells, cell zero holds the head
    for (genvar g = 0; g < fqa_pkg::DEPTH; g++)
    begin : g_cell
        localparam int CellNum = g;
        fqa_pkg::cell_ctl_t ctl;
        fqa_pkg::rec_t      neighbor;

        assign ctl.shift = deq_ok;
        assign ctl.load  = enq_ok && (count_reg == CellNum[fqa_pkg::CNT_W-1:0]);
        assign ctl.age   = age_op;

        if (g == fqa_pkg::DEPTH - 1)
        begin : g_last
            assign neighbor = '0;
        end
        else
        begin : g_mid
            assign neighbor = cell_rec[g + 1];
        end

        fqa_cell u_cell (
            .clk          (clk),
            .ctl          (ctl),
            .load_rec     (load_rec),
            .neighbor_rec (neighbor),
            .elapsed      (elapsed_time),
            .rec          (cell_rec[g])
        );
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_arrival = out_rec_reg.arrival;
    assign out_service = out_rec_reg.service;
    assign out_wait    = out_rec_reg.waited;
    assign occupancy   = count_reg;
    assign is_empty    = (count_reg == fqa_pkg::CNT_ZERO);

    // count never passes the queue depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= fqa_pkg::CNT_FULL)
        else $error("record count above depth");

    // a stored enqueue grows the count by one
    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        enq_ok |=> count_reg == $past(count_reg) + fqa_pkg::CNT_ONE)
        else $error("enqueue did not advance count");

    // a successful dequeue shrinks the count by one and reports ok
    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        deq_ok |=> (count_reg == $past(count_reg) - fqa_pkg::CNT_ONE)
                   && (status_reg == fqa_pkg::ST_OK))
        else $error("dequeue did not retire a record");

    // input side stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with no pending result");

endmodule

/* rtl/core/fqa_cell.sv */
module fqa_cell (
    input  logic               clk,
    input  fqa_pkg::cell_ctl_t ctl,
    input  fqa_pkg::rec_t      load_rec,
    input  fqa_pkg::rec_t      neighbor_rec,
    input  fqa_pkg::time_t     elapsed,
    output fqa_pkg::rec_t      rec
);

    fqa_pkg::rec_t rec_reg;
    fqa_pkg::rec_t rec_next;

    // shift toward the head on dequeue, load on enqueue, age the wait
    always_comb
    begin
        rec_next = rec_reg;
        if (ctl.shift)
        begin
            rec_next = neighbor_rec;
        end
        else if (ctl.load)
        begin
            rec_next = load_rec;
        end
        else if (ctl.age)
        begin
            rec_next.waited = fqa_pkg::sat_add(rec_reg.waited, elapsed);
        end
    end

    // record storage
    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule
